// File: hdl/sdsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared double stack package
// Sizes, operation and status codes used by the stack unit and its RAM.
// ----------------------------------------------------------------------------
package sdsu_pkg;

  // Storage shape
  localparam int DEPTH  = 128;
  localparam int WIDTH  = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Interface field widths
  localparam int MODE_W = 3;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int CAP_W  = 8;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(128);

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_L = 3'd0,
    MODE_PUSH_R = 3'd1,
    MODE_POP_L  = 3'd2,
    MODE_POP_R  = 3'd3,
    MODE_PEEK_L = 3'd4,
    MODE_PEEK_R = 3'd5
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // One access to the shared store
  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [WIDTH-1:0]  wdata;
  } mem_req_t;

endpackage

// File: hdl/sdsu_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Single-port RAM
// One read or write per cycle; read data registered.
// ----------------------------------------------------------------------------
module sdsu_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i && we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && !we_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/shared_array_double_stack_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared array double stack unit
// Two stacks in one RAM: left grows up from entry 0, right grows down from
// the entry below the configured capacity (saturated at the RAM depth). Push, pop and peek on either side.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+-------------------------------
//  request  | start & !busy                  | mode, push_value
//  result   | result_valid_o (one cycle)     | read_value_o, status_o,
//           |                                | left_empty_o, right_empty_o
//  config   | cfg_valid_i & cfg_ready_o      | cfg_capacity_i
//
//  Cycles : one request per cycle unless busy; result in the cycle after
//           acceptance, set by the registered read port of the store RAM.
//  Reset  : both stacks empty, capacity 128. No clearing of the RAM: an
//           entry is only ever read after a push has written it.
//  Stalls : the receiver cannot stall. busy is high only while a config
//           write is offered; config is refused while a result is out.
//
// ----------------------------------------------------------------------------
module shared_array_double_stack_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request
  input  logic                              start,
  output logic                              busy,
  input  logic [sdsu_pkg::MODE_W-1:0]       mode_i,
  input  logic signed [sdsu_pkg::DATA_W-1:0] push_value_i,
  // result
  output logic                              result_valid_o,
  output logic signed [sdsu_pkg::DATA_W-1:0] read_value_o,
  output logic [sdsu_pkg::STAT_W-1:0]       status_o,
  output logic                              left_empty_o,
  output logic                              right_empty_o,
  // configuration
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sdsu_pkg::CAP_W-1:0]        cfg_capacity_i
);

  localparam int CNT_W  = sdsu_pkg::CNT_W;
  localparam int ADDR_W = sdsu_pkg::ADDR_W;

  // Control state
  logic [CNT_W-1:0]          left_count_q, left_count_d;
  logic [CNT_W-1:0]          right_count_q, right_count_d;
  logic [sdsu_pkg::CAP_W-1:0] capacity_q;
  logic                      result_valid_q;

  // Result payload
  sdsu_pkg::status_e         status_q, status_d;
  logic                      rd_sel_q, rd_sel_d;
  logic                      left_empty_q, right_empty_q;

  logic                      req_accept;
  logic                      cfg_accept;
  logic [CNT_W-1:0]          eff_cap;
  logic [CNT_W:0]            used;
  logic                      room;
  logic [CNT_W-1:0]          addr_full;
  sdsu_pkg::mem_req_t        mem_req;
  logic [sdsu_pkg::WIDTH-1:0] mem_rdata;

  assign busy        = cfg_valid_i;
  assign cfg_ready_o = !result_valid_q;
  assign req_accept  = start && !busy;
  assign cfg_accept  = cfg_valid_i && cfg_ready_o;

  // Capacity above the RAM depth saturates
  always_comb begin
    if (32'(capacity_q) > 32'(sdsu_pkg::DEPTH)) begin
      eff_cap = CNT_W'(sdsu_pkg::DEPTH);
    end else begin
      eff_cap = CNT_W'(capacity_q);
    end
  end

  assign used = {1'b0, left_count_q} + {1'b0, right_count_q};
  assign room = used < {1'b0, eff_cap};

  // Decode: at most one RAM access and pointer update per request
  always_comb begin
    left_count_d  = left_count_q;
    right_count_d = right_count_q;
    status_d      = sdsu_pkg::ST_OK;
    rd_sel_d      = 1'b0;
    addr_full     = '0;
    mem_req.en    = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.wdata = sdsu_pkg::WIDTH'($unsigned(push_value_i));

    unique case (sdsu_pkg::mode_e'(mode_i))
      sdsu_pkg::MODE_PUSH_L: begin
        if (room) begin
          addr_full    = left_count_q;
          mem_req.en   = 1'b1;
          mem_req.we   = 1'b1;
          left_count_d = left_count_q + CNT_W'(1);
        end else begin
          status_d = sdsu_pkg::ST_FULL;
        end
      end
      sdsu_pkg::MODE_PUSH_R: begin
        if (room) begin
          addr_full     = eff_cap - CNT_W'(1) - right_count_q;
          mem_req.en    = 1'b1;
          mem_req.we    = 1'b1;
          right_count_d = right_count_q + CNT_W'(1);
        end else begin
          status_d = sdsu_pkg::ST_FULL;
        end
      end
      sdsu_pkg::MODE_POP_L, sdsu_pkg::MODE_PEEK_L: begin
        if (left_count_q == '0) begin
          status_d = sdsu_pkg::ST_EMPTY;
        end else begin
          addr_full  = left_count_q - CNT_W'(1);
          mem_req.en = 1'b1;
          rd_sel_d   = 1'b1;
          if (mode_i == sdsu_pkg::MODE_POP_L) begin
            left_count_d = left_count_q - CNT_W'(1);
          end
        end
      end
      sdsu_pkg::MODE_POP_R, sdsu_pkg::MODE_PEEK_R: begin
        if (right_count_q == '0) begin
          status_d = sdsu_pkg::ST_EMPTY;
        end else begin
          addr_full  = eff_cap - right_count_q;
          mem_req.en = 1'b1;
          rd_sel_d   = 1'b1;
          if (mode_i == sdsu_pkg::MODE_POP_R) begin
            right_count_d = right_count_q - CNT_W'(1);
          end
        end
      end
      default: begin
        // unused codes: no operation
      end
    endcase

    // Nothing moves unless the request is taken
    if (!req_accept) begin
      mem_req.en    = 1'b0;
      left_count_d  = left_count_q;
      right_count_d = right_count_q;
    end
    // A capacity write moves the right base, so both stacks are emptied
    if (cfg_accept) begin
      left_count_d  = '0;
      right_count_d = '0;
    end
    mem_req.addr = addr_full[ADDR_W-1:0];
  end

  // Store RAM: a push written at acceptance is visible to the next read,
  // so back-to-back push/pop of one entry needs no forwarding
  sdsu_ram #(
    .DEPTH (sdsu_pkg::DEPTH),
    .WIDTH (sdsu_pkg::WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (mem_req.en),
    .we_i    (mem_req.we),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_count_q   <= '0;
      right_count_q  <= '0;
      capacity_q     <= sdsu_pkg::CAP_RESET;
      result_valid_q <= 1'b0;
    end else begin
      left_count_q   <= left_count_d;
      right_count_q  <= right_count_d;
      result_valid_q <= req_accept;
      if (cfg_accept) begin
        capacity_q <= cfg_capacity_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_accept) begin
      status_q      <= status_d;
      rd_sel_q      <= rd_sel_d;
      left_empty_q  <= (left_count_d == '0);
      right_empty_q <= (right_count_d == '0);
    end
  end

  // Read data comes straight off the RAM output register
  assign result_valid_o = result_valid_q;
  assign read_value_o   = rd_sel_q ? sdsu_pkg::DATA_W'(mem_rdata) : '0;
  assign status_o       = status_q;
  assign left_empty_o   = left_empty_q;
  assign right_empty_o  = right_empty_q;

  // Assertions
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used <= {1'b0, eff_cap})
    else $error("stacks overlap beyond capacity");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_accept |=> result_valid_o)
    else $error("accepted request gave no result");

  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_accept && !cfg_accept && status_d == sdsu_pkg::ST_FULL)
      |=> (left_count_q == $past(left_count_q)
           && right_count_q == $past(right_count_q)))
    else $error("refused push moved a pointer");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o != sdsu_pkg::ST_OK) |-> read_value_o == '0)
    else $error("refused request returned data");

  a_cfg_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_accept && cfg_accept))
    else $error("config write taken together with a request");

endmodule
